FILE: rtl/valid_2d_convolution_defines.svh
`ifndef VALID_2D_CONVOLUTION_DEFINES_SVH
`define VALID_2D_CONVOLUTION_DEFINES_SVH

// same-cycle implication, checked outside reset
`define VCV_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define VCV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/vcv_pkg.sv
package vcv_pkg;

  localparam int KR        = 3;
  localparam int KC        = 3;
  localparam int MAX_WIDTH = 1024;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROWID_W    = $clog2(KR + 1);
  localparam int ROW_W      = 16;
  localparam int OCOL_W     = 10;
  localparam int WIDTH_W    = 11;
  localparam int PIX_W      = 16;
  localparam int COEF_W     = 16;
  localparam int IDX_W      = 4;
  localparam int PROD_W     = PIX_W + COEF_W;
  localparam int SUM_W      = 35;
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 1;

  localparam int IN_FIELDS_W  = IDX_W + COEF_W + PIX_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SUM_W + ROW_W + OCOL_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = CFG_ADDR_W'(1);

  localparam logic FUNC_COEF  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  typedef struct packed {
    logic win_en;
    logic pipe_en;
  } vcv_ctrl_t;

  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         idx;
    logic signed [COEF_W-1:0] value;
  } vcv_coef_t;

endpackage

FILE: rtl/valid_2d_convolution.sv
// Valid-mode 3x3 convolution over a raster pixel stream, stride one.
// Input channel (in_): in_tuser = 0 loads one kernel coefficient,
// in_tuser = 1 delivers one pixel in raster order. Coefficient loads give
// no result and apply to every pixel accepted after them.
// Output channel (out_): one result per pixel whose full window is present,
// with output-map row/column; out_tlast marks the last result of the frame.
// Config port: cfg_we writes image_width (index 0) or image_height
// (index 1) and restarts the frame; write only while the block is idle.
// Throughput: one item per cycle while out_tready does not stall the output.
// A result is presented after its pixel is accepted and has passed the
// line-buffer read, window/multiply, row sum, cross-row add and output register.
// A stall on out_tready freezes the whole pipeline; in_tready follows the
// output register (low only while a result waits and out_tready is low).
// Reset (synchronous, rst_n low): kernel clears to zero, counters to zero,
// width and height to 1024. Line buffers are not cleared; entries not yet
// written within the frame may be read, but they feed no result.
`include "valid_2d_convolution_defines.svh"

module valid_2d_convolution (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // coef_index, coef_value, pixel
  input  logic [vcv_pkg::IN_DATA_W-1:0]        in_tdata,
  // func
  input  logic [0:0]                           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // conv_sum, out_row, out_col
  output logic [vcv_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                 out_tlast,
  input  logic                                 cfg_we,
  input  logic [vcv_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [vcv_pkg::CFG_W-1:0]            cfg_wdata
);
  import vcv_pkg::*;

  typedef struct packed {
    logic              last;
    logic [ROW_W-1:0]  orow;
    logic [OCOL_W-1:0] ocol;
  } meta_t;

  logic [COL_W-1:0] w_m1_r, w_m1_nxt;
  logic [ROW_W-1:0] h_m1_r, h_m1_nxt;
  logic             cfg_hit;
  logic [COL_W-1:0] col_cnt_r;
  logic [ROW_W-1:0] row_cnt_r;

  logic adv, accept, pix_acc, emit_a;
  meta_t meta_a;

  logic                    s1_pix_r, s1_emit_r;
  logic [COL_W-1:0]        s1_col_r;
  logic signed [PIX_W-1:0] s1_px_r;
  meta_t                   s1_meta_r;
  logic                    s2_v_r, s3_v_r, out_valid_r;
  meta_t                   s2_meta_r, s3_meta_r, out_meta_r;
  logic signed [SUM_W-1:0] out_sum_r;

  logic [IDX_W-1:0]         in_idx;
  logic signed [COEF_W-1:0] in_coef;
  logic signed [PIX_W-1:0]  in_px;

  vcv_ctrl_t ctrl;
  vcv_coef_t coef;

  logic signed [PIX_W-1:0] lb_q [KR];
  logic signed [SUM_W-1:0] psum [KR+1];

  assign in_idx  = in_tdata[IDX_W-1:0];
  assign in_coef = in_tdata[IDX_W+COEF_W-1:IDX_W];
  assign in_px   = in_tdata[IDX_W+COEF_W+PIX_W-1:IDX_W+COEF_W];

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign accept    = in_tvalid && in_tready;
  assign pix_acc   = accept && (in_tuser[0] == FUNC_PIXEL);

  // config: clamp at write time, store size minus one
  always_comb begin
    int wv;
    int hv;
    wv = int'(cfg_wdata[WIDTH_W-1:0]);
    hv = int'(cfg_wdata[ROW_W-1:0]);
    if (wv < KC) begin
      wv = KC;
    end else if (wv > MAX_WIDTH) begin
      wv = MAX_WIDTH;
    end
    if (hv < KR) begin
      hv = KR;
    end
    w_m1_nxt = COL_W'(wv - 1);
    h_m1_nxt = ROW_W'(hv - 1);
    case (cfg_addr)
      REG_IMAGE_WIDTH:  cfg_hit = cfg_we;
      REG_IMAGE_HEIGHT: cfg_hit = cfg_we;
      default:          cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r <= COL_W'(MAX_WIDTH - 1);
      h_m1_r <= ROW_W'(1023);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH:  w_m1_r <= w_m1_nxt;
        REG_IMAGE_HEIGHT: h_m1_r <= h_m1_nxt;
        default: ;
      endcase
    end
  end

  // raster position of the incoming pixel
  always_comb begin
    emit_a      = (int'(row_cnt_r) >= KR - 1) && (int'(col_cnt_r) >= KC - 1);
    meta_a.last = (row_cnt_r == h_m1_r) && (col_cnt_r == w_m1_r);
    meta_a.orow = ROW_W'(int'(row_cnt_r) - (KR - 1));
    meta_a.ocol = OCOL_W'(int'(col_cnt_r) - (KC - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (cfg_hit) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (pix_acc) begin
      if (col_cnt_r == w_m1_r) begin
        col_cnt_r <= '0;
        row_cnt_r <= (row_cnt_r == h_m1_r) ? '0 : row_cnt_r + ROW_W'(1);
      end else begin
        col_cnt_r <= col_cnt_r + COL_W'(1);
      end
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_pix_r    <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_pix_r    <= pix_acc;
      s2_v_r      <= s1_pix_r && s1_emit_r;
      s3_v_r      <= s2_v_r;
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_emit_r  <= emit_a;
      s1_col_r   <= col_cnt_r;
      s1_px_r    <= in_px;
      s1_meta_r  <= meta_a;
      s2_meta_r  <= s1_meta_r;
      s3_meta_r  <= s2_meta_r;
      out_meta_r <= s3_meta_r;
      out_sum_r  <= psum[KR];
    end
  end

  // line buffers: each row hands its old value to the row above
  assign lb_q[KR-1] = s1_px_r;

  for (genvar r = 0; r < KR - 1; r++) begin : g_lb
    vcv_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_lb (
      .clk   (clk),
      .we    (adv && s1_pix_r),
      .waddr (s1_col_r),
      .wdata (lb_q[r+1]),
      .re    (pix_acc),
      .raddr (col_cnt_r),
      .rdata (lb_q[r])
    );
  end

  assign ctrl.win_en  = adv && s1_pix_r;
  assign ctrl.pipe_en = adv;
  assign coef.we      = accept && (in_tuser[0] == FUNC_COEF);
  assign coef.idx     = in_idx;
  assign coef.value   = in_coef;

  assign psum[0] = '0;

  for (genvar r = 0; r < KR; r++) begin : g_cell
    vcv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .row_id   (ROWID_W'(r)),
      .ctrl     (ctrl),
      .coef     (coef),
      .col_in   (lb_q[r]),
      .psum_in  (psum[r]),
      .psum_out (psum[r+1])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_meta_r.last;
  assign out_tdata  = OUT_DATA_W'({out_meta_r.ocol, out_meta_r.orow, out_sum_r});

  `VCV_ASSERT_IMPL(a_col_in_range, 1'b1, col_cnt_r <= w_m1_r,
                   "column counter beyond row width")
  `VCV_ASSERT_IMPL(a_row_in_range, 1'b1, row_cnt_r <= h_m1_r,
                   "row counter beyond frame height")
  `VCV_ASSERT_NEXT(a_stall_freeze, !in_tready,
                   $stable({s1_pix_r, s2_v_r, s3_v_r, out_valid_r}),
                   "pipeline moved during output stall")

endmodule

FILE: rtl/vcv_ram.sv
module vcv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/vcv_cell.sv
module vcv_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [vcv_pkg::ROWID_W-1:0]         row_id,
  input  vcv_pkg::vcv_ctrl_t                  ctrl,
  input  vcv_pkg::vcv_coef_t                  coef,
  input  logic signed [vcv_pkg::PIX_W-1:0]    col_in,
  input  logic signed [vcv_pkg::SUM_W-1:0]    psum_in,
  output logic signed [vcv_pkg::SUM_W-1:0]    psum_out
);
  import vcv_pkg::*;

  logic signed [PIX_W-1:0]  win_r   [KC];
  logic signed [PIX_W-1:0]  win_nxt [KC];
  logic signed [COEF_W-1:0] kern_r  [KC];
  logic signed [PROD_W-1:0] prod_r  [KC];
  logic signed [SUM_W-1:0]  rsum_r;
  logic signed [SUM_W-1:0]  rsum_nxt;

  always_comb begin
    for (int c = 0; c < KC - 1; c++) begin
      win_nxt[c] = win_r[c + 1];
    end
    win_nxt[KC-1] = col_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < KC; c++) begin
        kern_r[c] <= '0;
      end
    end else begin
      for (int c = 0; c < KC; c++) begin
        if (coef.we && (int'(coef.idx) == int'(row_id) * KC + c)) begin
          kern_r[c] <= coef.value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.win_en) begin
      for (int c = 0; c < KC; c++) begin
        win_r[c] <= win_nxt[c];
      end
    end
    if (ctrl.pipe_en) begin
      for (int c = 0; c < KC; c++) begin
        prod_r[c] <= PROD_W'(win_nxt[c]) * PROD_W'(kern_r[c]);
      end
      rsum_r <= rsum_nxt;
    end
  end

  always_comb begin
    rsum_nxt = '0;
    for (int c = 0; c < KC; c++) begin
      rsum_nxt = rsum_nxt + SUM_W'(prod_r[c]);
    end
  end

  assign psum_out = psum_in + rsum_r;

endmodule
